### src/fcr_pkg.sv
// shared constants and types for the framed command receiver
`default_nettype none
package fcr_pkg;

	// frame layout constants
	localparam int unsigned MAX_PARAMS     = 8;
	localparam logic [7:0]  PREAMBLE_A     = 8'h4D;
	localparam logic [7:0]  PREAMBLE_B     = 8'h58;
	localparam logic [7:0]  CHECK_SEED     = 8'hAA;
	localparam logic [7:0]  ADDRESS_RESET  = 8'h42;

	// widths of the result fields
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned SLOT_W   = 3;
	localparam int unsigned PARAMS_W = MAX_PARAMS * BYTE_W;

	// result of one byte beat from the parser
	typedef struct packed {
		logic                hit;
		logic [BYTE_W-1:0]   command_code;
		logic [COUNT_W-1:0]  param_count;
		logic [PARAMS_W-1:0] param_bytes;
	} fcr_result_t;

endpackage
`default_nettype wire

### src/fcr_parser.sv
// frame hunting state machine, parameter store and checksum
`default_nettype none
module fcr_parser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                beat_en,
	input  wire logic [7:0]          rx_byte,
	input  wire logic [7:0]          board_address,
	output fcr_pkg::fcr_result_t     result
);
	import fcr_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SECOND,
		PH_ADDR,
		PH_CMD,
		PH_LEN,
		PH_PARAM,
		PH_CHECK
	} phase_t;

	phase_t              phase_q;
	logic [COUNT_W-1:0]  bytes_left_q;
	logic [COUNT_W-1:0]  write_slot_q;
	logic [BYTE_W-1:0]   running_check_q;
	logic [BYTE_W-1:0]   held_command_q;
	logic [COUNT_W-1:0]  held_count_q;
	logic [BYTE_W-1:0]   param_store_q [MAX_PARAMS];

	logic                len_too_big;
	logic [PARAMS_W-1:0] packed_params;

	assign len_too_big = ({{(32-BYTE_W){1'b0}}, rx_byte} > MAX_PARAMS);

	// pack stored parameters, slots at or above the count read as zero
	always_comb begin
		packed_params = '0;
		for (int k = 0; k < MAX_PARAMS; k++) begin
			if (k < 32'(held_count_q)) begin
				packed_params[k*BYTE_W +: BYTE_W] = param_store_q[k];
			end
		end
	end

	// result for the current beat
	always_comb begin
		result.hit          = beat_en && (phase_q == PH_CHECK)
		                      && ((running_check_q ^ rx_byte) == '0);
		result.command_code = held_command_q;
		result.param_count  = held_count_q;
		result.param_bytes  = packed_params;
	end

	// phase sequencing and frame capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			bytes_left_q    <= '0;
			write_slot_q    <= '0;
			running_check_q <= '0;
			held_command_q  <= '0;
			held_count_q    <= '0;
			for (int k = 0; k < MAX_PARAMS; k++) begin
				param_store_q[k] <= '0;
			end
		end else if (beat_en) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == PREAMBLE_A) begin
						phase_q <= PH_SECOND;
					end
				end
				PH_SECOND: begin
					phase_q <= (rx_byte == PREAMBLE_B) ? PH_ADDR : PH_HUNT;
				end
				PH_ADDR: begin
					phase_q <= (rx_byte == board_address) ? PH_CMD : PH_HUNT;
				end
				PH_CMD: begin
					held_command_q  <= rx_byte;
					running_check_q <= CHECK_SEED ^ rx_byte;
					phase_q         <= PH_LEN;
				end
				PH_LEN: begin
					if (len_too_big) begin
						phase_q <= PH_HUNT;
					end else begin
						held_count_q    <= rx_byte[COUNT_W-1:0];
						bytes_left_q    <= rx_byte[COUNT_W-1:0];
						write_slot_q    <= '0;
						running_check_q <= running_check_q ^ rx_byte;
						phase_q         <= (rx_byte != '0) ? PH_PARAM : PH_CHECK;
					end
				end
				PH_PARAM: begin
					param_store_q[write_slot_q[SLOT_W-1:0]] <= rx_byte;
					running_check_q <= running_check_q ^ rx_byte;
					write_slot_q    <= write_slot_q + COUNT_W'(1);
					bytes_left_q    <= bytes_left_q - COUNT_W'(1);
					if (bytes_left_q == COUNT_W'(1)) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### src/framed_command_receiver.sv
// top level of the framed command receiver: handshakes, address register, result register
//
// Usage:
//   Input channel rx_byte / in_valid / in_ready carries one received serial
//   byte per beat. The block hunts for frames 'M' 'X' address command length
//   params check, where check makes 0xAA ^ command ^ length ^ params ^ check
//   equal to zero. Frames with a wrong preamble, address, length or check
//   give no result.
//   Output channel command_code / param_count / param_bytes with out_valid /
//   out_ready carries one beat per good frame; unused parameter bytes are zero.
//   cfg_we / cfg_wdata write board_address (reset 0x42). The user must write it only
//   while the block is idle; the block itself leaves this unchecked. The result is
//   registered when the check byte is taken and offered in the next cycle. Throughput:
//   one byte per cycle while in_ready is high; the result register holds one entry.
//   Stall: while a result waits and out_ready is low, in_ready is low; it rises
//   again in the cycle the result is taken.
//   Reset: arst_n clears the parser to hunting, empties the result register
//   and restores the board address.
`default_nettype none
module framed_command_receiver (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [7:0]                   cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [7:0]                   rx_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [7:0]                        command_code,
	output logic [fcr_pkg::COUNT_W-1:0]       param_count,
	output logic [fcr_pkg::PARAMS_W-1:0]      param_bytes
);
	import fcr_pkg::*;

	logic [BYTE_W-1:0]   address_q;
	logic                in_beat;
	fcr_result_t         result;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   command_code_q;
	logic [COUNT_W-1:0]  param_count_q;
	logic [PARAMS_W-1:0] param_bytes_q;

	// a new beat is taken whenever the result register is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign in_beat  = in_valid && in_ready;

	// board address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= ADDRESS_RESET;
		end else if (cfg_we) begin
			address_q <= cfg_wdata;
		end
	end

	fcr_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat_en       (in_beat),
		.rx_byte       (rx_byte),
		.board_address (address_q),
		.result        (result)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= result.hit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (in_beat && result.hit) begin
			command_code_q <= result.command_code;
			param_count_q  <= result.param_count;
			param_bytes_q  <= result.param_bytes;
		end
	end

	assign out_valid    = out_valid_q;
	assign command_code = command_code_q;
	assign param_count  = param_count_q;
	assign param_bytes  = param_bytes_q;

endmodule
`default_nettype wire
